[src/dmmr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmr_pkg
// Shared widths, item kind codes and the control bundle that travels from
// the sequencer to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package dmmr_pkg;

  // field widths
  localparam int KIND_W    = 2;
  localparam int IDX_W     = 4;
  localparam int DATA_W    = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = 36;

  // rows and columns reachable by a 4-bit index
  localparam int ADDR_SPAN = 1 << IDX_W;

  // default matrix dimension
  localparam int N_DEFAULT = 16;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROW  = 2'd2;

  // tag that rides along with each operand pair
  typedef struct packed {
    logic vld;
    logic first;
    logic lastk;
  } mac_ctl_t;

endpackage

[src/dmmr_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmmr_mac
// Shared multiply-accumulate unit: one registered 16x16 signed multiply
// followed by a 36-bit accumulate, with a one-cycle done pulse after the
// final term of a dot product.
// ----------------------------------------------------------------------------
module dmmr_mac
  import dmmr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] a_op,
  input  logic signed [DATA_W-1:0] b_op,
  output logic signed [SUM_W-1:0]  acc,
  output logic                     done
);

  mac_ctl_t                 p_ctl;
  logic signed [PROD_W-1:0] prod;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
    end else begin
      p_ctl <= ctl;
    end
    prod <= a_op * b_op;
  end

  // accumulate stage, restarts on the first term
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p_ctl.vld & p_ctl.lastk;
    end
    if (p_ctl.vld) begin
      if (p_ctl.first) begin
        acc <= SUM_W'(prod);
      end else begin
        acc <= acc + SUM_W'(prod);
      end
    end
  end

endmodule

[src/dense_matrix_multiply_rows_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dense_matrix_multiply_rows_core
// Integer matrix multiply C = A*B over signed 16-bit elements held in two
// on-chip stores. Load beats write single elements; a row beat streams out
// one row of C, one beat per column, with the final column marked.
// ----------------------------------------------------------------------------
//
//  channel | beat content                | handshake
//  --------+-----------------------------+-------------------------
//  input   | kind, row, col, value       | in_valid / in_stall
//  output  | out_row, out_col, sum, last | out_valid / out_stall
//
// A load beat is written into its store when accepted. A row beat holds
// the block through every column of the row, with DIM = min(N,16):
// each column runs DIM reads through one shared multiply-accumulate unit,
// a pipeline drain through the tag, product and accumulate registers and an output step.
// in_stall is high for the whole row; a stalled output beat holds the
// sequencer before it loads the next column.
// Reset clears the control state only; store contents are undefined until
// written.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_rows_core
  import dmmr_pkg::*;
#(
  parameter int N = N_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  input  logic signed [DATA_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_row,
  output logic [IDX_W-1:0]         out_col,
  output logic signed [SUM_W-1:0]  sum,
  output logic                     last
);

  // working dimension and store geometry
  localparam int DIM   = (N < ADDR_SPAN) ? N : ADDR_SPAN;
  localparam int DEPTH = DIM * ADDR_SPAN;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_W:0]   DIM_V  = (IDX_W + 1)'(DIM);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_PUT   = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] ri;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;

  logic signed [DATA_W-1:0] a_mem [DEPTH];
  logic signed [DATA_W-1:0] b_mem [DEPTH];
  logic signed [DATA_W-1:0] a_rd;
  logic signed [DATA_W-1:0] b_rd;

  logic                    in_acc;
  logic                    in_range;
  logic                    wr_a;
  logic                    wr_b;
  logic                    start;
  logic                    issue;
  logic                    out_free;
  logic [2*IDX_W-1:0]      wr_full;
  logic [2*IDX_W-1:0]      ra_full;
  logic [2*IDX_W-1:0]      rb_full;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           ra_addr;
  logic [AW-1:0]           rb_addr;
  mac_ctl_t                s1_ctl;
  logic signed [SUM_W-1:0] acc;
  logic                    done;

  // input decode
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign in_range = ({1'b0, row} < DIM_V) && ({1'b0, col} < DIM_V);
  assign wr_a     = in_acc && (kind == KIND_WR_A) && in_range;
  assign wr_b     = in_acc && (kind == KIND_WR_B) && in_range;
  assign start    = in_acc && (kind == KIND_ROW) && ({1'b0, row} < DIM_V);
  assign issue    = (state == ST_RUN);
  assign out_free = ~out_valid | ~out_stall;

  // store addresses, row-major
  assign wr_full = {row, col};
  assign ra_full = {ri, k};
  assign rb_full = {k, j};
  assign wr_addr = wr_full[AW-1:0];
  assign ra_addr = ra_full[AW-1:0];
  assign rb_addr = rb_full[AW-1:0];

  // store A
  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_mem[wr_addr] <= value;
    end
    a_rd <= a_mem[ra_addr];
  end

  // store B
  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_mem[wr_addr] <= value;
    end
    b_rd <= b_mem[rb_addr];
  end

  // tag aligned with the read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.vld   <= issue;
      s1_ctl.first <= (k == '0);
      s1_ctl.lastk <= (k == IDX_MAX);
    end
  end

  dmmr_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (s1_ctl),
    .a_op (a_rd),
    .b_op (b_rd),
    .acc  (acc),
    .done (done)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_RUN;
      ST_RUN:   if (k == IDX_MAX) state_next = ST_DRAIN;
      ST_DRAIN: if (done) state_next = ST_PUT;
      ST_PUT: begin
        if (out_free) begin
          state_next = (j == IDX_MAX) ? ST_IDLE : ST_RUN;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        j <= '0;
        k <= '0;
      end else if (issue) begin
        k <= (k == IDX_MAX) ? '0 : k + 1'b1;
      end else if (state == ST_PUT && out_free) begin
        j <= j + 1'b1;
      end
    end
    if (start) begin
      ri <= row;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_PUT && out_free) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
    if (state == ST_PUT && out_free) begin
      out_row <= ri;
      out_col <= j;
      sum     <= acc;
      last    <= (j == IDX_MAX);
    end
  end

`ifndef SYNTHESIS
  // a finished dot product only arrives while the sequencer waits for it
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> state == ST_DRAIN)
    else $error("mac result outside drain");

  // each row starts at the first column and first term
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    start |=> (j == '0) && (k == '0) && (state == ST_RUN))
    else $error("row did not start cleanly");

  // a held output beat keeps the sequencer waiting
  a_put_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && out_valid && out_stall) |=> state == ST_PUT)
    else $error("output overwritten while stalled");

  // the marked beat is always the final column
  a_last_col: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PUT && out_free) |=> (last == (out_col == IDX_MAX)))
    else $error("last marker on wrong column");
`endif

endmodule
